// ===== rtl/core/sha1c_pkg.sv =====
package sha1c_pkg;

    // initial chaining words
    localparam logic [31:0] IV_H0 = 32'h6745_2301;
    localparam logic [31:0] IV_H1 = 32'hEFCD_AB89;
    localparam logic [31:0] IV_H2 = 32'h98BA_DCFE;
    localparam logic [31:0] IV_H3 = 32'h1032_5476;
    localparam logic [31:0] IV_H4 = 32'hC3D2_E1F0;

    // round constants
    localparam logic [31:0] K_CH   = 32'h5A82_7999;
    localparam logic [31:0] K_PAR1 = 32'h6ED9_EBA1;
    localparam logic [31:0] K_MAJ  = 32'h8F1B_BCDC;
    localparam logic [31:0] K_PAR2 = 32'hCA62_C1D6;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam int         ROUNDS     = 80;
    localparam int         RND_W      = 7;
    localparam int         FILL_W     = 6;
    localparam int         COUNT_W    = 61;
    localparam int         DIGEST_W   = 160;

    // round function select, one per group of twenty rounds
    typedef enum logic [1:0] {
        F_CH   = 2'd0,
        F_PAR1 = 2'd1,
        F_MAJ  = 2'd2,
        F_PAR2 = 2'd3
    } fsel_t;

    // controller to datapath
    typedef struct packed {
        logic  accept;     // input request taken this cycle
        logic  load_work;  // copy chaining words into working registers
        logic  round_en;   // run one compression round
        fsel_t fsel;
        logic  add_en;     // fold working registers into chaining words
        logic  pad_en;     // place 0x80 at fill point, zero the rest
        logic  len_en;     // write bit length into last two words
        logic  len_clear;  // zero the whole block before the length
        logic  finish;     // load digest, re-arm
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic fill_last;   // next byte completes the block
        logic fill_ge56;   // no room left for the length
        logic out_free;    // digest register can take a new result
    } status_t;

    function automatic logic [31:0] rotl1(input logic [31:0] x);
        rotl1 = {x[30:0], x[31]};
    endfunction

    function automatic logic [31:0] rotl5(input logic [31:0] x);
        rotl5 = {x[26:0], x[31:27]};
    endfunction

    function automatic logic [31:0] rotl30(input logic [31:0] x);
        rotl30 = {x[1:0], x[31:2]};
    endfunction

    function automatic logic [31:0] round_fn(input fsel_t sel, input logic [31:0] b,
                                             input logic [31:0] c, input logic [31:0] d);
        case (sel)
            F_CH:    round_fn = (b & c) | (~b & d);
            F_MAJ:   round_fn = (b & c) | (b & d) | (c & d);
            default: round_fn = b ^ c ^ d;
        endcase
    endfunction

    function automatic logic [31:0] round_k(input fsel_t sel);
        case (sel)
            F_CH:    round_k = K_CH;
            F_PAR1:  round_k = K_PAR1;
            F_MAJ:   round_k = K_MAJ;
            default: round_k = K_PAR2;
        endcase
    endfunction

endpackage

// ===== rtl/core/sha1c_ctrl.sv =====
module sha1c_ctrl (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic              byte_valid,
    input  logic              msg_last,
    input  sha1c_pkg::status_t status,
    output sha1c_pkg::cmd_t    cmd
);
    import sha1c_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE  = 7'b000_0001,
        S_ROUND = 7'b000_0010,
        S_ADD   = 7'b000_0100,
        S_PAD   = 7'b000_1000,
        S_LENZ  = 7'b001_0000,
        S_LEN   = 7'b010_0000,
        S_FIN   = 7'b100_0000
    } state_t;

    // where to go once a block compression has finished
    typedef enum logic [1:0] {
        RET_IDLE = 2'd0,
        RET_PAD  = 2'd1,
        RET_LENZ = 2'd2,
        RET_FIN  = 2'd3
    } ret_t;

    localparam logic [RND_W-1:0] RND_LAST = RND_W'(ROUNDS - 1);

    state_t            state_reg, state_next;
    ret_t              ret_reg, ret_next;
    logic [RND_W-1:0]  rnd_reg, rnd_next;

    // state, return code and round counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            ret_reg   <= RET_IDLE;
            rnd_reg   <= '0;
        end else begin
            state_reg <= state_next;
            ret_reg   <= ret_next;
            rnd_reg   <= rnd_next;
        end
    end

    assign s_axis_tready = (state_reg == S_IDLE);

    // next state and commands
    always_comb begin
        state_next = state_reg;
        ret_next   = ret_reg;
        rnd_next   = rnd_reg;
        cmd        = '0;
        if (rnd_reg < RND_W'(20)) begin
            cmd.fsel = F_CH;
        end else if (rnd_reg < RND_W'(40)) begin
            cmd.fsel = F_PAR1;
        end else if (rnd_reg < RND_W'(60)) begin
            cmd.fsel = F_MAJ;
        end else begin
            cmd.fsel = F_PAR2;
        end
        unique case (state_reg)
            S_IDLE: begin
                if (s_axis_tvalid) begin
                    cmd.accept = 1'b1;
                    if (byte_valid && status.fill_last) begin
                        cmd.load_work = 1'b1;
                        state_next    = S_ROUND;
                        ret_next      = msg_last ? RET_PAD : RET_IDLE;
                    end else if (msg_last) begin
                        state_next = S_PAD;
                    end
                end
            end
            S_ROUND: begin
                cmd.round_en = 1'b1;
                if (rnd_reg == RND_LAST) begin
                    rnd_next   = '0;
                    state_next = S_ADD;
                end else begin
                    rnd_next = rnd_reg + RND_W'(1);
                end
            end
            S_ADD: begin
                cmd.add_en = 1'b1;
                unique case (ret_reg)
                    RET_IDLE: state_next = S_IDLE;
                    RET_PAD:  state_next = S_PAD;
                    RET_LENZ: state_next = S_LENZ;
                    RET_FIN:  state_next = S_FIN;
                    default:  state_next = S_IDLE;
                endcase
            end
            S_PAD: begin
                cmd.pad_en = 1'b1;
                if (status.fill_ge56) begin
                    cmd.load_work = 1'b1;
                    state_next    = S_ROUND;
                    ret_next      = RET_LENZ;
                end else begin
                    state_next = S_LEN;
                end
            end
            S_LENZ: begin
                cmd.len_en    = 1'b1;
                cmd.len_clear = 1'b1;
                cmd.load_work = 1'b1;
                state_next    = S_ROUND;
                ret_next      = RET_FIN;
            end
            S_LEN: begin
                cmd.len_en    = 1'b1;
                cmd.load_work = 1'b1;
                state_next    = S_ROUND;
                ret_next      = RET_FIN;
            end
            S_FIN: begin
                if (status.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // exactly eighty rounds, then the feed-forward add
    a_round_count: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_ROUND && rnd_reg == RND_LAST) |=> (state_reg == S_ADD))
        else $error("round loop did not end after the last round");

    a_rnd_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_ROUND) |-> (rnd_reg == '0))
        else $error("round counter not cleared outside the round loop");

    // padding that overflows needs an extra block before the length
    a_pad_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_PAD && status.fill_ge56) |=>
        (state_reg == S_ROUND && ret_reg == RET_LENZ))
        else $error("overflowing pad did not start an extra block");

endmodule

// ===== rtl/core/sha1c_datapath.sv =====
module sha1c_datapath (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  sha1c_pkg::cmd_t                cmd,
    output sha1c_pkg::status_t             status,
    input  logic [7:0]                     data_byte,
    input  logic                           byte_valid,
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    output logic [sha1c_pkg::DIGEST_W-1:0] m_axis_tdata
);
    import sha1c_pkg::*;

    logic [31:0]          h_reg [5];
    logic [31:0]          h_next [5];
    logic [31:0]          a_reg, b_reg, c_reg, d_reg, e_reg;
    logic [31:0]          a_next, b_next, c_next, d_next, e_next;
    logic [31:0]          w_reg [16];
    logic [31:0]          w_next [16];
    logic [FILL_W-1:0]    fill_reg, fill_next;
    logic [COUNT_W-1:0]   count_reg, count_next;
    logic [DIGEST_W-1:0]  dig_reg, dig_next;
    logic                 out_valid_reg, out_valid_next;
    logic [31:0]          temp;
    logic [63:0]          bit_len;
    logic [FILL_W-1:0]    pos;
    logic                 take_byte;

    assign take_byte = cmd.accept && byte_valid;
    assign bit_len   = {count_reg, 3'b000};

    assign status.fill_last = (fill_reg == '1);
    assign status.fill_ge56 = (fill_reg >= FILL_W'(56));
    assign status.out_free  = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = dig_reg;

    // control state: fill point, length, result valid, chaining words
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
            h_reg[0]      <= IV_H0;
            h_reg[1]      <= IV_H1;
            h_reg[2]      <= IV_H2;
            h_reg[3]      <= IV_H3;
            h_reg[4]      <= IV_H4;
        end else begin
            fill_reg      <= fill_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
            h_reg         <= h_next;
        end
    end

    // payload: working variables, message window, digest
    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        c_reg   <= c_next;
        d_reg   <= d_next;
        e_reg   <= e_next;
        w_reg   <= w_next;
        dig_reg <= dig_next;
    end

    // byte counting, output handshake and re-arm
    always_comb begin
        fill_next      = fill_reg;
        count_next     = count_reg;
        out_valid_next = out_valid_reg;
        if (take_byte) begin
            fill_next  = fill_reg + FILL_W'(1);
            count_next = count_reg + COUNT_W'(1);
        end
        if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
        if (cmd.finish) begin
            fill_next      = '0;
            count_next     = '0;
            out_valid_next = 1'b1;
        end
    end

    // one round of the compression
    assign temp = rotl5(a_reg) + round_fn(cmd.fsel, b_reg, c_reg, d_reg) + e_reg
                + round_k(cmd.fsel) + w_reg[0];

    always_comb begin
        a_next = a_reg;
        b_next = b_reg;
        c_next = c_reg;
        d_next = d_reg;
        e_next = e_reg;
        if (cmd.load_work) begin
            a_next = h_reg[0];
            b_next = h_reg[1];
            c_next = h_reg[2];
            d_next = h_reg[3];
            e_next = h_reg[4];
        end else if (cmd.round_en) begin
            a_next = temp;
            b_next = a_reg;
            c_next = rotl30(b_reg);
            d_next = c_reg;
            e_next = d_reg;
        end
    end

    // chaining words: feed-forward add, re-arm after the digest
    always_comb begin
        h_next = h_reg;
        if (cmd.add_en) begin
            h_next[0] = h_reg[0] + a_reg;
            h_next[1] = h_reg[1] + b_reg;
            h_next[2] = h_reg[2] + c_reg;
            h_next[3] = h_reg[3] + d_reg;
            h_next[4] = h_reg[4] + e_reg;
        end else if (cmd.finish) begin
            h_next[0] = IV_H0;
            h_next[1] = IV_H1;
            h_next[2] = IV_H2;
            h_next[3] = IV_H3;
            h_next[4] = IV_H4;
        end
    end

    // digest register, word0 in the low bits
    always_comb begin
        dig_next = dig_reg;
        if (cmd.finish) begin
            dig_next = {h_reg[4], h_reg[3], h_reg[2], h_reg[1], h_reg[0]};
        end
    end

    // message window: byte writes, padding, length, schedule shift
    always_comb begin
        w_next = w_reg;
        pos    = '0;
        if (take_byte) begin
            w_next[fill_reg[5:2]][{~fill_reg[1:0], 3'b000} +: 8] = data_byte;
        end else if (cmd.round_en) begin
            for (int i = 0; i < 15; i++) begin
                w_next[i] = w_reg[i + 1];
            end
            w_next[15] = rotl1(w_reg[13] ^ w_reg[8] ^ w_reg[2] ^ w_reg[0]);
        end else if (cmd.pad_en) begin
            for (int wi = 0; wi < 16; wi++) begin
                for (int bi = 0; bi < 4; bi++) begin
                    pos = {4'(wi), 2'(bi)};
                    if (pos == fill_reg) begin
                        w_next[wi][8 * (3 - bi) +: 8] = PAD_BYTE;
                    end else if (pos > fill_reg) begin
                        w_next[wi][8 * (3 - bi) +: 8] = 8'h00;
                    end
                end
            end
        end else if (cmd.len_en) begin
            if (cmd.len_clear) begin
                for (int i = 0; i < 14; i++) begin
                    w_next[i] = '0;
                end
            end
            w_next[14] = bit_len[63:32];
            w_next[15] = bit_len[31:0];
        end
    end

    a_rearm: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.finish |=> (fill_reg == '0 && count_reg == '0 && out_valid_reg))
        else $error("digest issued without re-arming the counters");

    a_feed_forward: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.add_en |=> (h_reg[0] == $past(h_reg[0] + a_reg)))
        else $error("feed-forward add of the first chaining word wrong");

    a_length: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.len_en |=> ({w_reg[14], w_reg[15]} == {count_reg, 3'b000}))
        else $error("bit length not placed at the end of the block");

endmodule

// ===== rtl/core/sha1_message_hasher_core.sv =====
// SHA-1 hasher taking one message byte per input request (tuser[0] marks the
// byte as part of the message, tlast ends the message) and giving the 160-bit
// digest as one output request. Bytes that do not complete a 64-byte block are
// taken back to back. The byte that completes a block, or tlast, holds tready
// low while the single shared round unit runs: 80 rounds at one round per
// cycle, then the feed-forward add. A request with tlast pads the block,
// places the length, compresses the final block and loads the digest; when 56
// or more bytes of the last block are used, one more block is compressed
// before the length. A finished digest waits in its own register, so the next
// message is accepted while it is still untaken; the block only stalls if a
// second digest is ready before the first is read.
module sha1_message_hasher_core (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_axis_tvalid,
    output logic                           s_axis_tready,
    input  logic [7:0]                     s_axis_tdata,   // data_byte
    input  logic [0:0]                     s_axis_tuser,   // byte_valid
    input  logic                           s_axis_tlast,   // last
    output logic                           m_axis_tvalid,
    input  logic                           m_axis_tready,
    // digest_word0, digest_word1, digest_word2, digest_word3, digest_word4
    output logic [sha1c_pkg::DIGEST_W-1:0] m_axis_tdata
);
    import sha1c_pkg::*;

    cmd_t    cmd;
    status_t status;

    sha1c_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .byte_valid    (s_axis_tuser[0]),
        .msg_last      (s_axis_tlast),
        .status        (status),
        .cmd           (cmd)
    );

    sha1c_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .data_byte     (s_axis_tdata),
        .byte_valid    (s_axis_tuser[0]),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

    import sha1c_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 400000;
    localparam int unsigned LONG_HOLD   = 600;
    localparam int unsigned DRAIN_WAIT  = 200;
    localparam int unsigned ITEM_TARGET = 1000;
    localparam int unsigned QUIET_FROM  = 850;
    localparam int unsigned MIN_DIGESTS = 40;

    typedef logic [DIGEST_W-1:0] digest_t;

    // one row of the directed stimulus table
    typedef struct {
        logic [7:0] data;
        logic       byte_ok;
        logic       ends_msg;
        logic       typed;
        digest_t    digest;
    } stim_row_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_axis_tvalid = 1'b0;
    logic s_axis_tready;
    logic [7:0] s_axis_tdata = 8'h00;   // data_byte
    logic [0:0] s_axis_tuser = 1'b0;    // byte_valid
    logic s_axis_tlast = 1'b0;          // last
    logic m_axis_tvalid;
    logic m_axis_tready = 1'b0;
    // digest_word0, digest_word1, digest_word2, digest_word3, digest_word4
    logic [DIGEST_W-1:0] m_axis_tdata;

    // hasher state mirrored by the digest predictor
    logic [31:0] chain_words [5];
    logic [7:0] block_bytes [64];
    int unsigned block_fill;
    logic [COUNT_W-1:0] msg_bytes;

    digest_t digest_queue [$];
    stim_row_t dir_rows [$];

    int unsigned items_sent = 0;
    int unsigned digests_pred = 0;
    int unsigned digests_seen = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_cnt = 0;
    int unsigned gap_odds = 4;
    bit quiet = 1'b0;
    bit long_hold_req = 1'b0;
    bit long_hold_done = 1'b0;

    sha1_message_hasher_core u_dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #1 aclk = ~aclk;

    function automatic digest_t pack_words(input logic [31:0] w0, input logic [31:0] w1,
                                           input logic [31:0] w2, input logic [31:0] w3,
                                           input logic [31:0] w4);
        return {w4, w3, w2, w1, w0};
    endfunction

    task automatic restart_chain();
        chain_words[0] = IV_H0;
        chain_words[1] = IV_H1;
        chain_words[2] = IV_H2;
        chain_words[3] = IV_H3;
        chain_words[4] = IV_H4;
        block_fill = 0;
        msg_bytes = '0;
    endtask

    // 80 rounds over the current block, folded into the chaining words
    task automatic compress_block();
        logic [31:0] w [16];
        logic [31:0] a, b, c, d, e, f, k, wt, sum;
        fsel_t sel;
        for (int i = 0; i < 16; i++)
            w[i] = {block_bytes[4*i], block_bytes[4*i+1], block_bytes[4*i+2], block_bytes[4*i+3]};
        a = chain_words[0];
        b = chain_words[1];
        c = chain_words[2];
        d = chain_words[3];
        e = chain_words[4];
        for (int r = 0; r < ROUNDS; r++) begin
            if (r < 16) begin
                wt = w[r];
            end else begin
                wt = w[(r - 3) & 15] ^ w[(r - 8) & 15] ^ w[(r - 14) & 15] ^ w[r & 15];
                wt = {wt[30:0], wt[31]};
                w[r & 15] = wt;
            end
            sel = fsel_t'(r / 20);
            case (sel)
                F_CH: begin
                    f = (b & c) | (~b & d);
                    k = K_CH;
                end
                F_PAR1: begin
                    f = b ^ c ^ d;
                    k = K_PAR1;
                end
                F_MAJ: begin
                    f = (b & c) | (b & d) | (c & d);
                    k = K_MAJ;
                end
                default: begin
                    f = b ^ c ^ d;
                    k = K_PAR2;
                end
            endcase
            sum = {a[26:0], a[31:27]} + f + e + k + wt;
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = sum;
        end
        chain_words[0] += a;
        chain_words[1] += b;
        chain_words[2] += c;
        chain_words[3] += d;
        chain_words[4] += e;
    endtask

    // absorb one request; on end of message pad, finish and report the digest
    task automatic absorb_request(input logic [7:0] data, input logic byte_ok,
                                  input logic ends_msg, output logic done,
                                  output digest_t digest);
        logic [63:0] bit_len;
        done = 1'b0;
        digest = '0;
        if (byte_ok) begin
            block_bytes[block_fill] = data;
            block_fill++;
            msg_bytes++;
            if (block_fill == 64) begin
                compress_block();
                block_fill = 0;
            end
        end
        if (ends_msg) begin
            block_bytes[block_fill] = PAD_BYTE;
            for (int i = block_fill + 1; i < 64; i++)
                block_bytes[i] = 8'h00;
            // no room for the length: an extra block of padding
            if (block_fill >= 56) begin
                compress_block();
                for (int i = 0; i < 64; i++)
                    block_bytes[i] = 8'h00;
            end
            bit_len = {msg_bytes, 3'b000};
            for (int i = 0; i < 8; i++)
                block_bytes[63 - i] = bit_len[8*i +: 8];
            compress_block();
            digest = pack_words(chain_words[0], chain_words[1], chain_words[2],
                                chain_words[3], chain_words[4]);
            done = 1'b1;
            restart_chain();
        end
    endtask

    // offer one request, wait for it to be taken, then predict
    task automatic send_request(input logic [7:0] data, input logic byte_ok,
                                input logic ends_msg, input logic typed,
                                input digest_t typed_digest);
        logic done;
        digest_t digest;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= data;
        s_axis_tuser <= byte_ok;
        s_axis_tlast <= ends_msg;
        do @(posedge aclk); while (!s_axis_tready);
        if (byte_ok || ends_msg)
            items_sent++;
        absorb_request(data, byte_ok, ends_msg, done, digest);
        if (done) begin
            digests_pred++;
            digest_queue.push_back(typed ? typed_digest : digest);
        end
    endtask

    task automatic sender_gap();
        if (!quiet && gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge aclk);
        end
    endtask

    task automatic wait_all_digests();
        s_axis_tvalid <= 1'b0;
        do @(posedge aclk); while (digest_queue.size() != 0);
    endtask

    // mostly short messages, some around the block and padding boundaries
    function automatic int unsigned pick_len();
        int unsigned roll;
        roll = $urandom_range(0, 19);
        if (roll < 11)
            return $urandom_range(0, 20);
        else if (roll < 15)
            return $urandom_range(50, 70);
        else if (roll < 17)
            return $urandom_range(0, 140);
        else
            case ($urandom_range(0, 7))
                0: return 55;
                1: return 56;
                2: return 63;
                3: return 64;
                4: return 65;
                5: return 119;
                6: return 120;
                default: return 128;
            endcase
    endfunction

    // one message with random content and ignored bytes scattered in
    task automatic send_message(input int unsigned len);
        bit tail_byte;
        int unsigned body;
        tail_byte = (len > 0) && ($urandom_range(0, 1) == 1);
        body = tail_byte ? len - 1 : len;
        for (int unsigned n = 0; n < body; n++) begin
            while ($urandom_range(0, 9) == 0) begin
                sender_gap();
                send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0, 1'b0, '0);
            end
            sender_gap();
            send_request(8'($urandom_range(0, 255)), 1'b1, 1'b0, 1'b0, '0);
        end
        sender_gap();
        send_request(8'($urandom_range(0, 255)), tail_byte, 1'b1, 1'b0, '0);
    endtask

    task automatic check_digest(input digest_t got);
        digest_t want;
        digests_seen++;
        if (digest_queue.size() == 0) begin
            mismatches++;
            $error("digest %h arrived with none expected", got);
            return;
        end
        want = digest_queue.pop_front();
        for (int i = 0; i < 5; i++)
            if (got[32*i +: 32] !== want[32*i +: 32]) begin
                mismatches++;
                $error("digest_word%0d: expected %h, actual %h", i, want[32*i +: 32],
                       got[32*i +: 32]);
            end
    endtask

    // cycle watchdog
    initial begin
        while (cycle_cnt < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_cnt++;
        end
        $display("timeout after %0d cycles", cycle_cnt);
        $display("Mismatches found");
        $finish;
    end

    // result side: check taken digests, stall at random, one long hold
    initial begin : digest_sink
        int unsigned stall_left;
        int unsigned hold_left;
        stall_left = 0;
        hold_left = 0;
        wait (aresetn === 1'b1);
        forever begin
            @(posedge aclk);
            if (m_axis_tvalid && m_axis_tready)
                check_digest(m_axis_tdata);
            if (long_hold_req && !long_hold_done) begin
                hold_left = LONG_HOLD;
                long_hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_axis_tready <= 1'b0;
            end else if (stall_left > 0) begin
                stall_left--;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                if (!quiet && $urandom_range(0, 15) == 0)
                    stall_left = $urandom_range(1, 11);
            end
        end
    end

    // request side
    initial begin
        // empty messages, "abc" with ignored bytes, short messages and single bytes at the extremes
        dir_rows.push_back(stim_row_t'{8'h00, 1'b0, 1'b1, 1'b1,
            pack_words(32'hda39a3ee, 32'h5e6b4b0d, 32'h3255bfef, 32'h95601890, 32'hafd80709)});
        dir_rows.push_back(stim_row_t'{8'h61, 1'b1, 1'b0, 1'b0, '0});
        dir_rows.push_back(stim_row_t'{8'hFF, 1'b0, 1'b0, 1'b0, '0});
        dir_rows.push_back(stim_row_t'{8'h62, 1'b1, 1'b0, 1'b0, '0});
        dir_rows.push_back(stim_row_t'{8'h00, 1'b0, 1'b0, 1'b0, '0});
        dir_rows.push_back(stim_row_t'{8'h63, 1'b1, 1'b1, 1'b1,
            pack_words(32'ha9993e36, 32'h4706816a, 32'hba3e2571, 32'h7850c26c, 32'h9cd0d89d)});
        dir_rows.push_back(stim_row_t'{8'hFF, 1'b0, 1'b1, 1'b1,
            pack_words(32'hda39a3ee, 32'h5e6b4b0d, 32'h3255bfef, 32'h95601890, 32'hafd80709)});
        dir_rows.push_back(stim_row_t'{8'h00, 1'b1, 1'b0, 1'b0, '0});
        dir_rows.push_back(stim_row_t'{8'hFF, 1'b1, 1'b0, 1'b0, '0});
        dir_rows.push_back(stim_row_t'{8'hA5, 1'b0, 1'b1, 1'b0, '0});
        dir_rows.push_back(stim_row_t'{8'hFF, 1'b1, 1'b1, 1'b0, '0});
        dir_rows.push_back(stim_row_t'{8'h00, 1'b1, 1'b1, 1'b0, '0});
        dir_rows.push_back(stim_row_t'{8'h80, 1'b1, 1'b0, 1'b0, '0});
        dir_rows.push_back(stim_row_t'{8'h7F, 1'b1, 1'b0, 1'b0, '0});
        dir_rows.push_back(stim_row_t'{8'h5A, 1'b1, 1'b1, 1'b0, '0});

        for (int i = 0; i < 64; i++)
            block_bytes[i] = 8'h00;
        restart_chain();

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        foreach (dir_rows[i]) begin
            sender_gap();
            send_request(dir_rows[i].data, dir_rows[i].byte_ok, dir_rows[i].ends_msg,
                         dir_rows[i].typed, dir_rows[i].digest);
        end
        wait_all_digests();

        // back-to-back short messages against a long output hold
        gap_odds = 0;
        long_hold_req = 1'b1;
        repeat (8) send_message($urandom_range(0, 3));
        wait_all_digests();

        // random messages, last stretch without idling
        while (items_sent < ITEM_TARGET || digests_pred < MIN_DIGESTS) begin
            if (items_sent >= QUIET_FROM)
                quiet = 1'b1;
            gap_odds = ($urandom_range(0, 3) == 0) ? 0 : 4;
            send_message(pick_len());
        end

        wait_all_digests();
        repeat (DRAIN_WAIT) @(posedge aclk);

        $display("covered %0d message requests and %0d digests over %0d cycles,",
                 items_sent, digests_seen, cycle_cnt);
        $display("with ignored bytes, block-boundary lengths, idling and a full output stall");
        if (mismatches == 0 && digest_queue.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
